/* rtl/rpa_pkg.sv */
`default_nettype none

package rpa_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT     = 8;

   localparam int MODE_W   = 2;
   localparam int ID_W     = 8;
   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_LAND      = 2'd0,
      MODE_TAKEOFF   = 2'd1,
      MODE_EMERGENCY = 2'd2,
      MODE_VACATE    = 2'd3
   } mode_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_GRANT_LAND     = 3'd0,
      ACT_GRANT_TAKEOFF  = 3'd1,
      ACT_QUEUED_LAND    = 3'd2,
      ACT_QUEUED_TAKEOFF = 3'd3,
      ACT_QUEUED_FRONT   = 3'd4,
      ACT_IDLE           = 3'd5,
      ACT_REJECTED       = 3'd6
   } action_type;

   typedef struct packed {
      logic push_tail;
      logic push_front;
      logic pop;
   } queue_cmd_type;

endpackage

`default_nettype wire

/* rtl/runway_priority_arbiter.sv */
// The strobe comes from the result register, which lies behind the input register that takes the word.
// Throughput: one word per cycle; busy stays low, so start may be held high.
// Each word passes an input register, one step of queue and grant logic, and the
// result register; the queue head is kept pre-read so a pop finds it ready.
// Reset (synchronous): runway free, both queues empty; no strobe until a word.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module runway_priority_arbiter #(
   parameter int QUEUE_DEPTH = rpa_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = rpa_pkg::ID_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rpa_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [rpa_pkg::ID_W-1:0]      req_aircraft_id,
   output logic                               rsp_valid,
   output logic [rpa_pkg::ACTION_W-1:0]       rsp_action,
   output logic [rpa_pkg::ID_W-1:0]           rsp_served_id,
   output logic [rpa_pkg::POS_W-1:0]          rsp_queue_position
);
   import rpa_pkg::*;

   localparam int SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic           req_valid_ff;
   mode_type       req_mode_ff;
   logic [SW-1:0]  req_id_ff;

   logic           runway_free_ff, runway_free_in;

   queue_cmd_type  land_cmd, take_cmd;
   logic [CW-1:0]  land_count, take_count;
   logic [SW-1:0]  land_head_id, take_head_id;

   action_type     action_in;
   logic [SW-1:0]  served_in;
   logic [CW-1:0]  position_in;

   logic                 rsp_valid_ff;
   action_type           rsp_action_ff;
   logic [SW-1:0]        rsp_id_ff;
   logic [CW-1:0]        rsp_pos_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   // hold the word; ids keep only their low SW bits, the lesser of ID_BITS and ID_W
   always_ff @(posedge clock) begin
      if (start) begin
         req_mode_ff <= mode_type'(req_mode);
         req_id_ff   <= req_aircraft_id[SW-1:0];
      end
   end

   rpa_decide #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (SW)
   ) u_decide (
      .valid          (req_valid_ff),
      .mode           (req_mode_ff),
      .id             (req_id_ff),
      .runway_free    (runway_free_ff),
      .land_count     (land_count),
      .land_head_id   (land_head_id),
      .take_count     (take_count),
      .take_head_id   (take_head_id),
      .land_cmd       (land_cmd),
      .take_cmd       (take_cmd),
      .runway_free_in (runway_free_in),
      .action         (action_in),
      .served_id      (served_in),
      .position       (position_in)
   );

   rpa_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (SW)
   ) u_land_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (land_cmd),
      .wr_id   (req_id_ff),
      .count   (land_count),
      .head_id (land_head_id)
   );

   rpa_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (SW)
   ) u_take_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (take_cmd),
      .wr_id   (req_id_ff),
      .count   (take_count),
      .head_id (take_head_id)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         runway_free_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         runway_free_ff <= runway_free_in;
         rsp_valid_ff   <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_action_ff <= action_in;
         rsp_id_ff     <= served_in;
         rsp_pos_ff    <= position_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = ACTION_W'(rsp_action_ff);
   assign rsp_served_id      = ID_W'(rsp_id_ff);
   assign rsp_queue_position = POS_W'(rsp_pos_ff);

endmodule

`default_nettype wire

/* rtl/rpa_queue.sv */
`default_nettype none

module rpa_queue #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rpa_pkg::queue_cmd_type        cmd,
   input  wire logic [DATA_W-1:0]             wr_id,
   output logic [$clog2(DEPTH+1)-1:0]         count,
   output logic [DATA_W-1:0]                  head_id
);
   import rpa_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] rd_ff;

   logic [PW:0]       tail_sum;
   logic [PW-1:0]     tail, head_inc, head_dec, wr_addr;
   logic              wr_en;

   always_comb begin
      tail_sum = (PW+1)'(head_ff) + (PW+1)'(count_ff);
      tail     = (tail_sum >= (PW+1)'(DEPTH)) ? PW'(tail_sum - (PW+1)'(DEPTH))
                                              : PW'(tail_sum);
      head_inc = (head_ff == PW'(DEPTH-1)) ? '0 : head_ff + 1'b1;
      head_dec = (head_ff == '0) ? PW'(DEPTH-1) : head_ff - 1'b1;

      wr_en   = cmd.push_tail | cmd.push_front;
      wr_addr = cmd.push_front ? head_dec : tail;

      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.push_front) begin
         head_in  = head_dec;
         count_in = count_ff + 1'b1;
      end else if (cmd.push_tail) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // keep the word at the next head in a register; forward a word written there
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_id;
      end
      if (wr_en && (wr_addr == head_in)) begin
         rd_ff <= wr_id;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   assign count   = count_ff;
   assign head_id = rd_ff;

endmodule

`default_nettype wire

/* rtl/rpa_decide.sv */
`default_nettype none

module rpa_decide #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 8
) (
   input  wire logic                          valid,
   input  wire rpa_pkg::mode_type             mode,
   input  wire logic [DATA_W-1:0]             id,
   input  wire logic                          runway_free,
   input  wire logic [$clog2(DEPTH+1)-1:0]    land_count,
   input  wire logic [DATA_W-1:0]             land_head_id,
   input  wire logic [$clog2(DEPTH+1)-1:0]    take_count,
   input  wire logic [DATA_W-1:0]             take_head_id,
   output rpa_pkg::queue_cmd_type             land_cmd,
   output rpa_pkg::queue_cmd_type             take_cmd,
   output logic                               runway_free_in,
   output rpa_pkg::action_type                action,
   output logic [DATA_W-1:0]                  served_id,
   output logic [$clog2(DEPTH+1)-1:0]         position
);
   import rpa_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   logic land_empty, take_empty, land_full, take_full;

   always_comb begin
      land_empty = (land_count == '0);
      take_empty = (take_count == '0);
      land_full  = (land_count == CW'(DEPTH));
      take_full  = (take_count == CW'(DEPTH));

      land_cmd       = '0;
      take_cmd       = '0;
      runway_free_in = runway_free;
      action         = ACT_IDLE;
      served_id      = id;
      position       = '0;

      if (valid) begin
         unique case (mode)
            MODE_LAND: begin
               if (runway_free && land_empty) begin
                  runway_free_in = 1'b0;
                  action         = ACT_GRANT_LAND;
               end else if (!land_full) begin
                  land_cmd.push_tail = 1'b1;
                  action             = ACT_QUEUED_LAND;
                  position           = land_count + 1'b1;
               end else begin
                  action = ACT_REJECTED;
               end
            end
            MODE_TAKEOFF: begin
               if (runway_free && land_empty && take_empty) begin
                  runway_free_in = 1'b0;
                  action         = ACT_GRANT_TAKEOFF;
               end else if (!take_full) begin
                  take_cmd.push_tail = 1'b1;
                  action             = ACT_QUEUED_TAKEOFF;
                  position           = take_count + 1'b1;
               end else begin
                  action = ACT_REJECTED;
               end
            end
            MODE_EMERGENCY: begin
               if (runway_free) begin
                  runway_free_in = 1'b0;
                  action         = ACT_GRANT_LAND;
               end else if (land_full) begin
                  action = ACT_REJECTED;
               end else begin
                  land_cmd.push_front = 1'b1;
                  action              = ACT_QUEUED_FRONT;
                  position            = land_count + 1'b1;
               end
            end
            MODE_VACATE: begin
               // landings drain before takeoffs; runway stays taken on a hand-over
               if (!land_empty) begin
                  land_cmd.pop   = 1'b1;
                  runway_free_in = 1'b0;
                  action         = ACT_GRANT_LAND;
                  served_id      = land_head_id;
               end else if (!take_empty) begin
                  take_cmd.pop   = 1'b1;
                  runway_free_in = 1'b0;
                  action         = ACT_GRANT_TAKEOFF;
                  served_id      = take_head_id;
               end else begin
                  runway_free_in = 1'b1;
                  action         = ACT_IDLE;
                  served_id      = '0;
               end
            end
            default: begin
               action = ACT_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
